>>> src/ctok_pkg.sv
// Shared types and constants of the C subset tokenizer.
package ctok_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 5;
  localparam int unsigned TdataW = ((KindW + 7) / 8) * 8;

  // Token kinds
  localparam logic [KindW-1:0] KIND_INT  = 5'd0;
  localparam logic [KindW-1:0] KIND_REAL = 5'd1;
  localparam logic [KindW-1:0] KIND_ID   = 5'd2;
  localparam logic [KindW-1:0] KIND_ADD  = 5'd7;
  localparam logic [KindW-1:0] KIND_SUB  = 5'd8;
  localparam logic [KindW-1:0] KIND_MUL  = 5'd9;
  localparam logic [KindW-1:0] KIND_DIV  = 5'd10;
  localparam logic [KindW-1:0] KIND_SEMI = 5'd11;
  localparam logic [KindW-1:0] KIND_LBRK = 5'd12;
  localparam logic [KindW-1:0] KIND_RBRK = 5'd13;
  localparam logic [KindW-1:0] KIND_COMMA = 5'd14;
  localparam logic [KindW-1:0] KIND_LPAR = 5'd15;
  localparam logic [KindW-1:0] KIND_RPAR = 5'd16;
  localparam logic [KindW-1:0] KIND_LBRC = 5'd17;
  localparam logic [KindW-1:0] KIND_RBRC = 5'd18;
  localparam logic [KindW-1:0] KIND_ASGN = 5'd19;
  localparam logic [KindW-1:0] KIND_STR  = 5'd20;
  localparam logic [KindW-1:0] KIND_MAX  = KIND_STR;

  // Output queue depth; the input stage needs room for two tokens
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_DOT,
    MODE_REAL,
    MODE_IDENT,
    MODE_STR
  } scan_mode_e;

  typedef enum logic [2:0] {
    KW_NONE,
    KW_CHAR,
    KW_FLOAT,
    KW_INT,
    KW_PUTS
  } kw_e;

  // Tokens produced by one byte: count and up to two kinds, in order
  typedef struct packed {
    logic [1:0]       cnt;
    logic [KindW-1:0] kind0;
    logic [KindW-1:0] kind1;
  } lex_res_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             last;
  } tok_entry_t;

endpackage

>>> src/c_subset_tokenizer.sv
// Top level of the C subset tokenizer: input register, scanner, token queue.
//
// Takes one text byte per transaction and returns the class codes of the tokens that each
// byte completes, zero, one or two of them, with tlast on the last token of a byte. A byte
// is taken every cycle while the queue has room. It is scanned from the input register and
// its tokens enter the four-entry token queue at the end of the cycle in which it is scanned,
// so the first token of a byte passes the input register and the token queue before it is
// offered. The output port moves one token per cycle while m_axis_tready is high. The input
// holds only while a byte waits and three or more tokens sit in the queue, which happens under
// output back-pressure or when bytes complete more than one token per cycle on average.
module c_subset_tokenizer import ctok_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ByteW-1:0]  s_axis_tdata,  // [7:0] text_byte
  input  logic              s_axis_tlast,  // end_of_text
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,  // [4:0] token_kind, [7:5] zero
  output logic              m_axis_tlast   // run_last
);

  logic             in_vld_q;
  logic [ByteW-1:0] byte_q;
  logic             eot_q;
  logic             step;
  logic             room;
  lex_res_t         res;

  tok_entry_t       queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;
  tok_entry_t       ent0, ent1;

  // Room for the worst case of two tokens, regardless of this cycle's pop
  assign room          = (cnt_q <= QCntW'(QDepth - 2));
  assign step          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata;
      eot_q  <= s_axis_tlast;
    end
  end

  ctok_lex u_lex (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .eot_i  (eot_q),
    .res_o  (res)
  );

  assign ent0.kind = res.kind0;
  assign ent0.last = (res.cnt == 2'd1);
  assign ent1.kind = res.kind1;
  assign ent1.last = 1'b1;

  assign pop = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (step) begin
      cnt_d = cnt_d + QCntW'(res.cnt);
    end
    if (pop) begin
      cnt_d = cnt_d - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (step) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(res.cnt);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && (res.cnt != 2'd0)) begin
      queue_q[wr_ptr_q] <= ent0;
    end
    if (step && (res.cnt == 2'd2)) begin
      queue_q[wr_ptr_q + QPtrW'(1)] <= ent1;
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = TdataW'(queue_q[rd_ptr_q].kind);
  assign m_axis_tlast  = queue_q[rd_ptr_q].last;

endmodule

>>> src/ctok_lex.sv
// Scanner state and the per-byte token decision.
module ctok_lex import ctok_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             eot_i,
  output lex_res_t         res_o
);

  scan_mode_e mode_q, mode_d;
  kw_e        cand_q, cand_d;
  logic [2:0] pos_q, pos_d;

  function automatic logic is_digit(input logic [ByteW-1:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [ByteW-1:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) || (b == 8'h5F);
  endfunction

  function automatic logic [2:0] kw_len(input kw_e c);
    logic [2:0] len;
    unique case (c)
      KW_CHAR:  len = 3'd4;
      KW_FLOAT: len = 3'd5;
      KW_INT:   len = 3'd3;
      KW_PUTS:  len = 3'd4;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [ByteW-1:0] kw_char(input kw_e c, input logic [2:0] p);
    logic [ByteW-1:0] ch;
    ch = 8'h00;
    unique case (c)
      KW_CHAR: begin
        unique case (p)
          3'd0: ch = 8'h63;
          3'd1: ch = 8'h68;
          3'd2: ch = 8'h61;
          3'd3: ch = 8'h72;
          default: ch = 8'h00;
        endcase
      end
      KW_FLOAT: begin
        unique case (p)
          3'd0: ch = 8'h66;
          3'd1: ch = 8'h6C;
          3'd2: ch = 8'h6F;
          3'd3: ch = 8'h61;
          3'd4: ch = 8'h74;
          default: ch = 8'h00;
        endcase
      end
      KW_INT: begin
        unique case (p)
          3'd0: ch = 8'h69;
          3'd1: ch = 8'h6E;
          3'd2: ch = 8'h74;
          default: ch = 8'h00;
        endcase
      end
      KW_PUTS: begin
        unique case (p)
          3'd0: ch = 8'h70;
          3'd1: ch = 8'h75;
          3'd2: ch = 8'h74;
          3'd3: ch = 8'h73;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [KindW-1:0] ident_kind(input kw_e c, input logic [2:0] p);
    if ((c != KW_NONE) && (p == kw_len(c))) begin
      return KIND_ID + KindW'(c);
    end
    return KIND_ID;
  endfunction

  // Single-character operators and punctuation; valid flag in the top bit
  function automatic logic [KindW:0] single_kind(input logic [ByteW-1:0] b);
    logic [KindW:0] r;
    unique case (b)
      8'h2B:   r = {1'b1, KIND_ADD};
      8'h2D:   r = {1'b1, KIND_SUB};
      8'h2A:   r = {1'b1, KIND_MUL};
      8'h2F:   r = {1'b1, KIND_DIV};
      8'h3B:   r = {1'b1, KIND_SEMI};
      8'h5B:   r = {1'b1, KIND_LBRK};
      8'h5D:   r = {1'b1, KIND_RBRK};
      8'h2C:   r = {1'b1, KIND_COMMA};
      8'h28:   r = {1'b1, KIND_LPAR};
      8'h29:   r = {1'b1, KIND_RPAR};
      8'h7B:   r = {1'b1, KIND_LBRC};
      8'h7D:   r = {1'b1, KIND_RBRC};
      8'h3D:   r = {1'b1, KIND_ASGN};
      default: r = '0;
    endcase
    return r;
  endfunction

  logic             used;
  logic             a_vld, b_vld, c_vld;
  logic [KindW-1:0] a_kind, b_kind, c_kind;
  logic [KindW:0]   single;

  always_comb begin
    mode_d = mode_q;
    cand_d = cand_q;
    pos_d  = pos_q;
    used   = 1'b0;
    a_vld  = 1'b0;
    a_kind = KIND_INT;
    b_vld  = 1'b0;
    b_kind = KIND_INT;
    c_vld  = 1'b0;
    c_kind = KIND_INT;
    single = single_kind(byte_i);

    // Extend or close the pending lexeme
    unique case (mode_q)
      MODE_INT: begin
        if (is_digit(byte_i)) begin
          used = 1'b1;
        end else if (byte_i == 8'h2E) begin
          mode_d = MODE_DOT;
          used   = 1'b1;
        end else begin
          a_vld  = 1'b1;
          a_kind = KIND_INT;
          mode_d = MODE_IDLE;
        end
      end
      MODE_DOT: begin
        // drop the lexeme when no digit follows the dot
        if (is_digit(byte_i)) begin
          mode_d = MODE_REAL;
          used   = 1'b1;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_REAL: begin
        if (is_digit(byte_i)) begin
          used = 1'b1;
        end else begin
          a_vld  = 1'b1;
          a_kind = KIND_REAL;
          mode_d = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (is_alpha(byte_i) || is_digit(byte_i)) begin
          used = 1'b1;
          if ((cand_q != KW_NONE) && (pos_q < kw_len(cand_q)) &&
              (kw_char(cand_q, pos_q) == byte_i)) begin
            pos_d = pos_q + 3'd1;
          end else begin
            cand_d = KW_NONE;
            pos_d  = 3'd0;
          end
        end else begin
          a_vld  = 1'b1;
          a_kind = ident_kind(cand_q, pos_q);
          mode_d = MODE_IDLE;
        end
      end
      MODE_STR: begin
        used = 1'b1;
        if (byte_i == 8'h22) begin
          a_vld  = 1'b1;
          a_kind = KIND_STR;
          mode_d = MODE_IDLE;
        end
      end
      default: mode_d = MODE_IDLE;
    endcase

    // Handle the byte from idle
    if (!used) begin
      priority if (is_digit(byte_i)) begin
        mode_d = MODE_INT;
      end else if (byte_i == 8'h2E) begin
        mode_d = MODE_DOT;
      end else if (is_alpha(byte_i)) begin
        mode_d = MODE_IDENT;
        pos_d  = 3'd1;
        priority case (byte_i)
          8'h63:   cand_d = KW_CHAR;
          8'h66:   cand_d = KW_FLOAT;
          8'h69:   cand_d = KW_INT;
          8'h70:   cand_d = KW_PUTS;
          default: begin
            cand_d = KW_NONE;
            pos_d  = 3'd0;
          end
        endcase
      end else if (byte_i == 8'h22) begin
        mode_d = MODE_STR;
      end else begin
        b_vld  = single[KindW];
        b_kind = single[KindW-1:0];
      end
    end

    // Flush a pending token at the end of the text
    if (eot_i) begin
      unique case (mode_d)
        MODE_INT: begin
          c_vld  = 1'b1;
          c_kind = KIND_INT;
        end
        MODE_REAL: begin
          c_vld  = 1'b1;
          c_kind = KIND_REAL;
        end
        MODE_IDENT: begin
          c_vld  = 1'b1;
          c_kind = ident_kind(cand_d, pos_d);
        end
        default: c_vld = 1'b0;
      endcase
      mode_d = MODE_IDLE;
      cand_d = KW_NONE;
      pos_d  = 3'd0;
    end
  end

  // Pack the at most two tokens in order
  always_comb begin
    res_o.cnt   = 2'({1'b0, a_vld} + {1'b0, b_vld} + {1'b0, c_vld});
    res_o.kind0 = a_vld ? a_kind : (b_vld ? b_kind : c_kind);
    res_o.kind1 = (a_vld && b_vld) ? b_kind : c_kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cand_q <= KW_NONE;
      pos_q  <= 3'd0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cand_q <= cand_d;
      pos_q  <= pos_d;
    end
  end

endmodule

>>> src/ctok_chk.sv
// Port-level checks of the C subset tokenizer and their binding.
module ctok_chk import ctok_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [TdataW-1:0] m_axis_tdata,
  input logic              m_axis_tlast
);

  // Hold a stalled token
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("token dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled token changed");

  // Only defined kinds leave, upper pad bits are zero
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[TdataW-1:KindW] == '0) &&
                      (m_axis_tdata[KindW-1:0] <= KIND_MAX))
    else $error("undefined token kind");

  // An empty output side never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A token follows an earlier byte transaction
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid, 2) || $past(s_axis_tvalid, 3) ||
                             !$past(s_axis_tready, 1) || !$past(s_axis_tready, 2))
    else $error("token without input");

endmodule

bind c_subset_tokenizer ctok_chk u_ctok_chk (.*);

>>> sim/token_checker.sv
// Checker for the C subset tokenizer: predicts tokens from the input stream and compares them.
module token_checker import ctok_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [ByteW-1:0]  s_tdata_i,
  input  logic              s_tlast_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [TdataW-1:0] m_tdata_i,
  input  logic              m_tlast_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  tok_entry_t  tokens_due[$];
  scan_mode_e  mode_q;
  kw_e         cand_q;
  logic [2:0]  pos_q;
  int unsigned errors;
  int unsigned pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic string kw_spelling(kw_e c);
    case (c)
      KW_CHAR:  return "char";
      KW_FLOAT: return "float";
      KW_INT:   return "int";
      KW_PUTS:  return "puts";
      default:  return "";
    endcase
  endfunction

  function automatic bit is_digit(logic [ByteW-1:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_word_start(logic [ByteW-1:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
  endfunction

  // msb set when the byte is a single-character operator or punctuation
  function automatic logic [KindW:0] punct_kind(logic [ByteW-1:0] b);
    case (b)
      "+":     return {1'b1, KIND_ADD};
      "-":     return {1'b1, KIND_SUB};
      "*":     return {1'b1, KIND_MUL};
      "/":     return {1'b1, KIND_DIV};
      ";":     return {1'b1, KIND_SEMI};
      "[":     return {1'b1, KIND_LBRK};
      "]":     return {1'b1, KIND_RBRK};
      ",":     return {1'b1, KIND_COMMA};
      "(":     return {1'b1, KIND_LPAR};
      ")":     return {1'b1, KIND_RPAR};
      "{":     return {1'b1, KIND_LBRC};
      "}":     return {1'b1, KIND_RBRC};
      "=":     return {1'b1, KIND_ASGN};
      default: return '0;
    endcase
  endfunction

  function automatic lex_res_t add_kind(lex_res_t r, logic [KindW-1:0] k);
    if (r.cnt == 2'd0) r.kind0 = k;
    else r.kind1 = k;
    r.cnt = r.cnt + 2'd1;
    return r;
  endfunction

  function automatic logic [KindW-1:0] word_kind();
    string sp;
    sp = kw_spelling(cand_q);
    if (cand_q != KW_NONE && int'(pos_q) == sp.len()) return KIND_ID + KindW'(cand_q);
    return KIND_ID;
  endfunction

  // Advance the scanner by one byte and return the tokens it completes
  function automatic lex_res_t lex_byte(logic [ByteW-1:0] b, logic eot);
    lex_res_t        res;
    bit              taken;
    logic [KindW:0]  pk;
    string           sp;
    res   = '0;
    taken = 1'b0;
    case (mode_q)
      MODE_INT: begin
        if (is_digit(b)) taken = 1'b1;
        else if (b == ".") begin
          mode_q = MODE_DOT;
          taken  = 1'b1;
        end else begin
          res    = add_kind(res, KIND_INT);
          mode_q = MODE_IDLE;
        end
      end
      MODE_DOT: begin
        // a dot with no digit after it drops the whole lexeme
        if (is_digit(b)) begin
          mode_q = MODE_REAL;
          taken  = 1'b1;
        end else mode_q = MODE_IDLE;
      end
      MODE_REAL: begin
        if (is_digit(b)) taken = 1'b1;
        else begin
          res    = add_kind(res, KIND_REAL);
          mode_q = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (is_word_start(b) || is_digit(b)) begin
          sp = kw_spelling(cand_q);
          if (cand_q != KW_NONE && int'(pos_q) < sp.len() && sp[pos_q] == b)
            pos_q = pos_q + 3'd1;
          else begin
            cand_q = KW_NONE;
            pos_q  = '0;
          end
          taken = 1'b1;
        end else begin
          res    = add_kind(res, word_kind());
          mode_q = MODE_IDLE;
        end
      end
      MODE_STR: begin
        if (b == "\"") begin
          res    = add_kind(res, KIND_STR);
          mode_q = MODE_IDLE;
        end
        taken = 1'b1;
      end
      default: mode_q = MODE_IDLE;
    endcase

    if (!taken) begin
      if (is_digit(b)) mode_q = MODE_INT;
      else if (b == ".") mode_q = MODE_DOT;
      else if (is_word_start(b)) begin
        mode_q = MODE_IDENT;
        pos_q  = 3'd1;
        case (b)
          "c":     cand_q = KW_CHAR;
          "f":     cand_q = KW_FLOAT;
          "i":     cand_q = KW_INT;
          "p":     cand_q = KW_PUTS;
          default: begin
            cand_q = KW_NONE;
            pos_q  = '0;
          end
        endcase
      end else if (b == "\"") mode_q = MODE_STR;
      else begin
        pk = punct_kind(b);
        if (pk[KindW]) res = add_kind(res, pk[KindW-1:0]);
      end
    end

    // flush a pending number or word at end of text, drop a dot or open string
    if (eot) begin
      if (mode_q == MODE_INT) res = add_kind(res, KIND_INT);
      else if (mode_q == MODE_REAL) res = add_kind(res, KIND_REAL);
      else if (mode_q == MODE_IDENT) res = add_kind(res, word_kind());
      mode_q = MODE_IDLE;
      cand_q = KW_NONE;
      pos_q  = '0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lex_res_t   res;
    tok_entry_t ent;
    if (!rst_ni) begin
      tokens_due.delete();
      mode_q  = MODE_IDLE;
      cand_q  = KW_NONE;
      pos_q   = '0;
      errors  = 0;
      pending = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (tokens_due.size() == 0) begin
          if (errors < 10)
            $display("unexpected token: tdata %0d last %0b", m_tdata_i, m_tlast_i);
          errors = errors + 1;
        end else begin
          ent = tokens_due.pop_front();
          if (m_tdata_i != TdataW'(ent.kind) || m_tlast_i != ent.last) begin
            if (errors < 10)
              $display("token mismatch: expected kind %0d last %0b, got tdata %0d last %0b",
                       ent.kind, ent.last, m_tdata_i, m_tlast_i);
            errors = errors + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        res = lex_byte(s_tdata_i, s_tlast_i);
        if (res.cnt != 2'd0) begin
          ent.kind = res.kind0;
          ent.last = (res.cnt == 2'd1);
          tokens_due.push_back(ent);
        end
        if (res.cnt == 2'd2) begin
          ent.kind = res.kind1;
          ent.last = 1'b1;
          tokens_due.push_back(ent);
        end
      end
      pending = tokens_due.size();
    end
  end

endmodule

>>> sim/testbench.sv
// Top of the tokenizer testbench: clock, reset, text stimulus and verdict.
module testbench;
  import ctok_pkg::*;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [ByteW-1:0]  s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic              m_axis_tlast;

  int unsigned errors;
  int unsigned pending;
  int unsigned sent = 0;
  bit          calm = 1'b0;

  string kw_list[4] = '{"char", "float", "int", "puts"};
  string ops        = "+-*/;[],(){}=";
  string blanks     = " \t\n";

  c_subset_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  token_checker tok_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tlast_i  (m_axis_tlast),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 31);
  end

  // Offer one byte, idling at random first; returns at the falling edge after the transaction
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eot);
    while (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit eot_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot_at_end && i == s.len() - 1);
  endtask

  // Hold the input until every predicted token has left the block
  task automatic drain_tokens();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  function automatic logic [ByteW-1:0] word_char(bit allow_digit);
    int unsigned r;
    r = $urandom_range(allow_digit ? 62 : 52);
    if (r < 26) return ByteW'("a" + r);
    if (r < 52) return ByteW'("A" + (r - 26));
    if (r == 52) return "_";
    return ByteW'("0" + (r - 53));
  endfunction

  function automatic logic [ByteW-1:0] digit_char();
    return ByteW'("0" + $urandom_range(9));
  endfunction

  // Build one random lexeme, mostly well formed, and stream it out
  task automatic send_lexeme();
    logic [ByteW-1:0] text[$];
    string            w;
    int unsigned      n;
    logic [ByteW-1:0] c;
    case ($urandom_range(9))
      0: begin
        n = $urandom_range(1, 4);
        repeat (n) text.push_back(digit_char());
        if ($urandom_range(3) == 0) begin
          text.push_back(".");
          repeat ($urandom_range(2)) text.push_back(digit_char());
        end
      end
      1: begin
        repeat ($urandom_range(2)) text.push_back(digit_char());
        text.push_back(".");
        repeat ($urandom_range(3)) text.push_back(digit_char());
      end
      2: begin
        w = kw_list[$urandom_range(3)];
        for (int i = 0; i < w.len(); i++) text.push_back(w[i]);
      end
      3: begin
        w = kw_list[$urandom_range(3)];
        for (int i = 0; i < w.len(); i++) text.push_back(w[i]);
        case ($urandom_range(2))
          0: repeat ($urandom_range(1, w.len() - 1)) void'(text.pop_back());
          1: text.push_back(word_char(1'b1));
          default: text[$urandom_range(1, w.len() - 1)] = word_char(1'b1);
        endcase
      end
      4: begin
        text.push_back(word_char(1'b0));
        repeat ($urandom_range(5)) text.push_back(word_char(1'b1));
      end
      5: begin
        text.push_back("\"");
        repeat ($urandom_range(4)) begin
          c = ByteW'($urandom_range(255));
          if (c == "\"") c = 8'h00;
          text.push_back(c);
        end
        if ($urandom_range(9) != 0) text.push_back("\"");
      end
      6, 7: text.push_back(ops[$urandom_range(ops.len() - 1)]);
      8: text.push_back(blanks[$urandom_range(blanks.len() - 1)]);
      default: text.push_back(ByteW'($urandom_range(255)));
    endcase
    foreach (text[i]) send_byte(text[i], $urandom_range(39) == 0);
  endtask

  initial begin
    #2_000_000;
    $display("** c_subset_tokenizer: FAILED **");
    $finish;
  end

  initial begin
    int unsigned guard;
    bit          drained_mid;
    drained_mid = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // high byte skipped, keyword ended by punctuation, real ended by a bracket
    send_byte(8'hFF, 1'b0);
    send_text("char[1.2]", 1'b0);
    // NUL inside a string literal
    send_text("puts(\"", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("\")", 1'b0);
    // dot without digit, then a keyword flushed at end of text
    send_text("9.x=", 1'b0);
    send_text(".5/float", 1'b1);
    drain_tokens();

    while (sent < 640) begin
      calm = (sent >= 250 && sent < 350);
      send_lexeme();
      if (!drained_mid && sent >= 450) begin
        drain_tokens();
        drained_mid = 1'b1;
      end
    end
    calm = 1'b0;

    s_axis_tvalid <= 1'b0;
    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (pending != 0 && guard < 20000);
    repeat (8) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("** c_subset_tokenizer: PASSED **");
    end else begin
      $display("** c_subset_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule

>>> c_subset_tokenizer.f
src/ctok_pkg.sv
src/ctok_lex.sv
src/c_subset_tokenizer.sv
src/ctok_chk.sv
sim/token_checker.sv
sim/testbench.sv
